// ===== design/shc_pkg.sv =====
// Shared types and constants for the stepper homing controller.
`timescale 1ns / 1ps

package shc_pkg;

   localparam int unsigned REQ_W       = 2;
   localparam int unsigned PERIOD_W    = 16;
   localparam int unsigned HALF_W      = 15;
   localparam int unsigned CONFIRM_W   = 4;
   localparam int unsigned POS_W       = 20;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_START = 2'd1;
   localparam logic [REQ_W-1:0] REQ_ABORT = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_STEPS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIDDLE_STEPS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_STEPS   = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0]    req_type;
      logic                limit_switch;
      logic [PERIOD_W-1:0] pulse_period;
      logic                axis_mode;
   } item_type;

   typedef struct packed {
      logic             step_pulse;
      logic             toward_base;
      logic             busy_res;
      logic             fault;
      logic [POS_W-1:0] position;
   } result_type;

endpackage

// ===== design/shc_seq.sv =====
// Homing sequencer: configuration registers, state and next-state logic for one item.
`timescale 1ns / 1ps

module shc_seq #(
   parameter int COUNT_BITS    = 20,
   parameter int CONFIRM_READS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [shc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [COUNT_BITS-1:0]            csr_wdata,
   input  logic                             advance,
   input  shc_pkg::item_type                item,
   output shc_pkg::result_type              result
);

   localparam int N = COUNT_BITS;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BACKOFF,
      PH_SEEK,
      PH_CONFIRM,
      PH_BASE,
      PH_MIDDLE
   } phase_type;

   typedef struct packed {
      phase_type                        ph;
      logic [N:0]                       sc;
      logic [shc_pkg::HALF_W-1:0]       ht;
      logic [shc_pkg::HALF_W-1:0]       hp;
      logic                             pl;
      logic                             dir;
      logic                             flt;
      logic [N-1:0]                     pc;
      logic                             md;
      logic [shc_pkg::CONFIRM_W-1:0]    cc;
   } st_type;

   typedef struct packed {
      logic [N-1:0] mx;
      logic [N-1:0] mid;
      logic [N-1:0] base;
   } cfg_type;

   cfg_type              cfg_ff;
   st_type               st_ff;
   st_type               st_in;
   logic [N+shc_pkg::POS_W-1:0] pos_wide;

   function automatic st_type go_idle(st_type s);
      st_type r;
      r    = s;
      r.ph = PH_IDLE;
      r.pl = 1'b0;
      r.ht = '0;
      return r;
   endfunction

   function automatic st_type begin_pulse(st_type s);
      st_type r;
      r    = s;
      r.pl = 1'b1;
      r.ht = '0;
      return r;
   endfunction

   function automatic logic [N-1:0] backoff_len(logic md, cfg_type c);
      logic [N-1:0] r;
      if (!md) begin
         r = c.mx >> 3;
      end else if (c.mid != '0) begin
         r = c.mid >> 1;
      end else begin
         r = c.mx >> 2;
      end
      return r;
   endfunction

   function automatic st_type enter_middle(st_type s, cfg_type c);
      st_type r;
      r     = s;
      r.pc  = '0;
      r.dir = 1'b0;
      r.ph  = PH_MIDDLE;
      if (c.mid == '0) begin
         r = go_idle(r);
      end else begin
         r = begin_pulse(r);
      end
      return r;
   endfunction

   function automatic st_type enter_base(st_type s, cfg_type c);
      st_type r;
      r     = s;
      r.sc  = '0;
      r.dir = 1'b1;
      r.ph  = PH_BASE;
      if (c.base == '0) begin
         r = enter_middle(r, c);
      end else begin
         r = begin_pulse(r);
      end
      return r;
   endfunction

   function automatic st_type after_seek(st_type s, cfg_type c);
      st_type r;
      r = s;
      if (r.md) begin
         r.cc = '0;
         r.ph = PH_CONFIRM;
         r.pl = 1'b0;
         r.ht = '0;
      end else begin
         r = enter_base(r, c);
      end
      return r;
   endfunction

   function automatic st_type enter_seek(st_type s, logic sw, cfg_type c);
      st_type r;
      r     = s;
      r.dir = 1'b1;
      r.ph  = PH_SEEK;
      r.sc  = r.md ? '0 : {1'b0, c.mx >> 3};
      if (sw) begin
         r = after_seek(r, c);
      end else begin
         r = begin_pulse(r);
      end
      return r;
   endfunction

   function automatic st_type step_done(st_type s, logic sw, cfg_type c);
      st_type r;
      r = s;
      unique case (r.ph)
         PH_BACKOFF: begin
            r.sc = r.sc + 1'b1;
            if (r.sc >= {1'b0, backoff_len(r.md, c)}) begin
               r = enter_seek(r, sw, c);
            end else begin
               r = begin_pulse(r);
            end
         end
         PH_SEEK: begin
            r.sc = r.sc + 1'b1;
            if (r.sc > {1'b0, c.mx}) begin
               r.flt = 1'b1;
               r     = go_idle(r);
            end else if (sw) begin
               r = after_seek(r, c);
            end else begin
               r = begin_pulse(r);
            end
         end
         PH_BASE: begin
            r.sc = r.sc + 1'b1;
            if (r.sc >= {1'b0, c.base}) begin
               r = enter_middle(r, c);
            end else begin
               r = begin_pulse(r);
            end
         end
         PH_MIDDLE: begin
            r.pc = r.pc + 1'b1;
            if (r.pc >= c.mid) begin
               r = go_idle(r);
            end else begin
               r = begin_pulse(r);
            end
         end
         default: r = go_idle(r);
      endcase
      return r;
   endfunction

   // Next state for the item held in the input register.
   always_comb begin
      st_in = st_ff;
      unique case (item.req_type)
         shc_pkg::REQ_TICK: begin
            if (st_ff.ph == PH_CONFIRM) begin
               if (!item.limit_switch) begin
                  st_in.flt = 1'b1;
                  st_in     = go_idle(st_in);
               end else begin
                  st_in.cc = st_ff.cc + 1'b1;
                  if (st_in.cc >= shc_pkg::CONFIRM_W'(CONFIRM_READS)) begin
                     st_in = enter_base(st_in, cfg_ff);
                  end
               end
            end else if (st_ff.ph != PH_IDLE) begin
               st_in.ht = st_ff.ht + 1'b1;
               if (st_in.ht >= st_ff.hp) begin
                  st_in.ht = '0;
                  if (st_ff.pl) begin
                     st_in.pl = 1'b0;
                  end else begin
                     st_in = step_done(st_in, item.limit_switch, cfg_ff);
                  end
               end
            end
         end
         shc_pkg::REQ_START: begin
            if (st_ff.ph == PH_IDLE) begin
               st_in.flt = 1'b0;
               st_in.md  = item.axis_mode;
               st_in.hp  = item.pulse_period[shc_pkg::PERIOD_W-1:1];
               if (st_in.hp == '0) begin
                  st_in.hp = shc_pkg::HALF_W'(1);
               end
               st_in.dir = 1'b1;
               if (item.limit_switch && (backoff_len(item.axis_mode, cfg_ff) != '0)) begin
                  st_in.ph  = PH_BACKOFF;
                  st_in.dir = 1'b0;
                  st_in.sc  = '0;
                  st_in     = begin_pulse(st_in);
               end else begin
                  st_in = enter_seek(st_in, item.limit_switch, cfg_ff);
               end
            end
         end
         shc_pkg::REQ_ABORT: begin
            if (st_ff.ph == PH_SEEK) begin
               st_in.flt = 1'b1;
            end
            if (st_ff.ph != PH_IDLE) begin
               st_in = go_idle(st_in);
            end
         end
         default: ;
      endcase
   end

   assign pos_wide = {{shc_pkg::POS_W{1'b0}}, st_in.pc};

   always_comb begin
      result.step_pulse  = st_in.pl;
      result.toward_base = st_in.dir;
      result.busy_res    = (st_in.ph != PH_IDLE);
      result.fault       = st_in.flt;
      result.position    = pos_wide[shc_pkg::POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            shc_pkg::CSR_MAX_STEPS:    cfg_ff.mx   <= csr_wdata;
            shc_pkg::CSR_MIDDLE_STEPS: cfg_ff.mid  <= csr_wdata;
            shc_pkg::CSR_BASE_STEPS:   cfg_ff.base <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{ph: PH_IDLE, dir: 1'b1, default: '0};
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

endmodule

// ===== design/stepper_homing_controller.sv =====
// Top level of the stepper homing controller: input register, sequencer and result register.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     req_type, limit_switch, pulse_period, axis_mode
//   rsp      out        rsp_valid / rsp_stall     step_pulse, toward_base, busy_res, fault, position
//   csr      in         csr_we (no wait)          csr_index, csr_wdata
//
// One item is accepted per clock while req_stall is low. An accepted item waits in the input register
// until it can advance; the sequencer's single-pass next-state logic runs on it, and its result is
// loaded into the result register as rsp_valid is set.
// Reset is synchronous and clears both valid flags, the sequencer state and the configuration registers.
// While rsp_stall holds, one more item is still taken into the input register; then
// req_stall rises until the result is taken.
`timescale 1ns / 1ps

module stepper_homing_controller #(
   parameter int COUNT_BITS    = 20,
   parameter int CONFIRM_READS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [shc_pkg::REQ_W-1:0]        req_type,
   input  logic                             req_limit_switch,
   input  logic [shc_pkg::PERIOD_W-1:0]     req_pulse_period,
   input  logic                             req_axis_mode,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_step_pulse,
   output logic                             rsp_toward_base,
   output logic                             rsp_busy_res,
   output logic                             rsp_fault,
   output logic [shc_pkg::POS_W-1:0]        rsp_position,
   input  logic                             csr_we,
   input  logic [shc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [COUNT_BITS-1:0]            csr_wdata
);

   logic                in_valid_ff;
   logic                in_valid_in;
   shc_pkg::item_type   item_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   shc_pkg::result_type res_ff;
   shc_pkg::result_type res_next;
   logic                advance;
   logic                take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.req_type     <= req_type;
         item_ff.limit_switch <= req_limit_switch;
         item_ff.pulse_period <= req_pulse_period;
         item_ff.axis_mode    <= req_axis_mode;
      end
      if (advance) begin
         res_ff <= res_next;
      end
   end

   shc_seq #(
      .COUNT_BITS    (COUNT_BITS),
      .CONFIRM_READS (CONFIRM_READS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .item      (item_ff),
      .result    (res_next)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_step_pulse  = res_ff.step_pulse;
   assign rsp_toward_base = res_ff.toward_base;
   assign rsp_busy_res    = res_ff.busy_res;
   assign rsp_fault       = res_ff.fault;
   assign rsp_position    = res_ff.position;

endmodule

// ===== design/shc_checker.sv =====
// Port-level checks for the stepper homing controller and the bind that attaches them.
`timescale 1ns / 1ps

module shc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_step_pulse,
   input logic                      rsp_busy_res,
   input logic                      rsp_fault
);

   // A held result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // With no result waiting, the block never stalls its input.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with the result register empty");

   // A failed run is never reported as still in progress.
   a_fault_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> !rsp_busy_res)
      else $error("fault shown while busy");

   // The step pin is only driven high during a run.
   a_pulse_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_pulse |-> rsp_busy_res)
      else $error("step pulse high while idle");

endmodule

bind stepper_homing_controller shc_checker u_shc_checker (.*);
